// ----- hw/rtl/fbpa_pkg.sv -----
// fbpa_pkg: types, codes and default constants of the fixed block pool allocator
// used by fbpa_csr, fbpa_ctrl, fbpa_datapath and fixed_block_pool_allocator
// depends on nothing
`default_nettype none

package fbpa_pkg;

   localparam int NUM_BLOCKS_DEFAULT   = 64;
   localparam int WORD_BYTES_DEFAULT   = 8;
   localparam int HEADER_BYTES_DEFAULT = 16;

   localparam logic [31:0] POOL_BASE_RESET      = 32'd0;
   localparam logic [15:0] BLOCK_CAPACITY_RESET = 16'd64;

   localparam int CSR_ADDR_W = 3;

   typedef enum logic {
      CSR_POOL_BASE      = 1'b0,
      CSR_BLOCK_CAPACITY = 1'b1
   } csr_index_type;

   typedef enum logic {
      KIND_ALLOC = 1'b0,
      KIND_FREE  = 1'b1
   } kind_type;

   typedef enum logic [2:0] {
      STATUS_GRANTED   = 3'd0,
      STATUS_POOL_FULL = 3'd1,
      STATUS_TOO_LARGE = 3'd2,
      STATUS_FREED     = 3'd3,
      STATUS_IGNORED   = 3'd4
   } status_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_ALIGN,
      ST_CORR,
      ST_PITCH,
      ST_SPAN,
      ST_DECIDE,
      ST_FETCH,
      ST_ADDR,
      ST_DIV,
      ST_PUSH,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic       latch;
      logic       align;
      logic       corr;
      logic       pitch;
      logic       span;
      logic       pop;
      logic       mul;
      logic       calc_addr;
      logic       div_start;
      logic       div_step;
      logic       push;
      logic       set_code;
      status_type code;
      logic       load_rsp;
   } cmd_type;

   typedef struct packed {
      logic kind_free;
      logic empty;
      logic too_large;
      logic reject_free;
      logic div_last;
   } stat_type;

endpackage

`default_nettype wire

// ----- hw/rtl/fbpa_ram.sv -----
// fbpa_ram: generic single write port, single read port ram with registered read
// no dependencies
`default_nettype none

module fbpa_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  wire                      clock,
   input  wire                      wr_en,
   input  wire [$clog2(DEPTH)-1:0]  wr_addr,
   input  wire [WIDTH-1:0]          wr_data,
   input  wire                      rd_en,
   input  wire [$clog2(DEPTH)-1:0]  rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ----- hw/rtl/fbpa_csr.sv -----
// fbpa_csr: apb-style register file holding pool base and block capacity
// depends on fbpa_pkg
`default_nettype none

module fbpa_csr (
   input  wire                               clock,
   input  wire                               reset,
   input  wire                               psel,
   input  wire                               penable,
   input  wire                               pwrite,
   input  wire [fbpa_pkg::CSR_ADDR_W-1:0]    paddr,
   input  wire [31:0]                        pwdata,
   output logic [31:0]                       prdata,
   output logic                              pready,
   output logic [31:0]                       pool_base,
   output logic [15:0]                       block_capacity
);

   logic [31:0] pool_base_ff;
   logic [15:0] block_capacity_ff;
   logic        wr_en;
   fbpa_pkg::csr_index_type index;

   assign index = fbpa_pkg::csr_index_type'(paddr[2]);
   assign wr_en = psel & penable & pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         pool_base_ff      <= fbpa_pkg::POOL_BASE_RESET;
         block_capacity_ff <= fbpa_pkg::BLOCK_CAPACITY_RESET;
      end else if (wr_en) begin
         unique case (index)
            fbpa_pkg::CSR_POOL_BASE:      pool_base_ff      <= pwdata;
            fbpa_pkg::CSR_BLOCK_CAPACITY: block_capacity_ff <= pwdata[15:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (index)
         fbpa_pkg::CSR_POOL_BASE:      prdata = pool_base_ff;
         fbpa_pkg::CSR_BLOCK_CAPACITY: prdata = {16'd0, block_capacity_ff};
         default:                      prdata = 32'd0;
      endcase
   end

   assign pready         = 1'b1;
   assign pool_base      = pool_base_ff;
   assign block_capacity = block_capacity_ff;

endmodule

`default_nettype wire

// ----- hw/rtl/fbpa_ctrl.sv -----
// fbpa_ctrl: sequencer of the allocator, one request at a time
// depends on fbpa_pkg; drives fbpa_datapath through cmd_type, reads stat_type
`default_nettype none

module fbpa_ctrl (
   input  wire                    clock,
   input  wire                    reset,
   input  wire                    req_valid,
   output logic                   req_ready,
   output logic                   rsp_valid,
   input  wire                    rsp_ready,
   input  fbpa_pkg::stat_type     stat,
   output fbpa_pkg::cmd_type      cmd
);

   fbpa_pkg::state_type state_ff, state_in;
   logic                rsp_valid_ff, rsp_valid_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= fbpa_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in     = state_ff;
      cmd          = '0;
      cmd.code     = fbpa_pkg::STATUS_GRANTED;
      req_ready    = 1'b0;
      rsp_valid_in = rsp_valid_ff & ~rsp_ready;
      unique case (state_ff)
         fbpa_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.latch = 1'b1;
               state_in  = fbpa_pkg::ST_ALIGN;
            end
         end
         fbpa_pkg::ST_ALIGN: begin
            cmd.align = 1'b1;
            state_in  = fbpa_pkg::ST_CORR;
         end
         fbpa_pkg::ST_CORR: begin
            cmd.corr = 1'b1;
            state_in = fbpa_pkg::ST_PITCH;
         end
         fbpa_pkg::ST_PITCH: begin
            cmd.pitch = 1'b1;
            state_in  = fbpa_pkg::ST_SPAN;
         end
         fbpa_pkg::ST_SPAN: begin
            cmd.span = 1'b1;
            state_in = fbpa_pkg::ST_DECIDE;
         end
         fbpa_pkg::ST_DECIDE: begin
            priority if (stat.kind_free && stat.reject_free) begin
               cmd.set_code = 1'b1;
               cmd.code     = fbpa_pkg::STATUS_IGNORED;
               state_in     = fbpa_pkg::ST_DONE;
            end else if (stat.kind_free) begin
               cmd.div_start = 1'b1;
               state_in      = fbpa_pkg::ST_DIV;
            end else if (stat.empty) begin
               cmd.set_code = 1'b1;
               cmd.code     = fbpa_pkg::STATUS_POOL_FULL;
               state_in     = fbpa_pkg::ST_DONE;
            end else if (stat.too_large) begin
               cmd.set_code = 1'b1;
               cmd.code     = fbpa_pkg::STATUS_TOO_LARGE;
               state_in     = fbpa_pkg::ST_DONE;
            end else begin
               cmd.pop  = 1'b1;
               state_in = fbpa_pkg::ST_FETCH;
            end
         end
         fbpa_pkg::ST_FETCH: begin
            cmd.mul  = 1'b1;
            state_in = fbpa_pkg::ST_ADDR;
         end
         fbpa_pkg::ST_ADDR: begin
            cmd.calc_addr = 1'b1;
            cmd.set_code  = 1'b1;
            cmd.code      = fbpa_pkg::STATUS_GRANTED;
            state_in      = fbpa_pkg::ST_DONE;
         end
         fbpa_pkg::ST_DIV: begin
            cmd.div_step = 1'b1;
            if (stat.div_last) begin
               state_in = fbpa_pkg::ST_PUSH;
            end
         end
         fbpa_pkg::ST_PUSH: begin
            cmd.push     = 1'b1;
            cmd.set_code = 1'b1;
            cmd.code     = fbpa_pkg::STATUS_FREED;
            state_in     = fbpa_pkg::ST_DONE;
         end
         fbpa_pkg::ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.load_rsp = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = fbpa_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = fbpa_pkg::ST_IDLE;
         end
      endcase
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

`default_nettype wire

// ----- hw/rtl/fbpa_datapath.sv -----
// fbpa_datapath: pitch arithmetic, free stack, restoring divider and result register
// depends on fbpa_pkg and fbpa_ram; steered by fbpa_ctrl through cmd_type
`default_nettype none

module fbpa_datapath #(
   parameter int NUM_BLOCKS   = fbpa_pkg::NUM_BLOCKS_DEFAULT,
   parameter int WORD_BYTES   = fbpa_pkg::WORD_BYTES_DEFAULT,
   parameter int HEADER_BYTES = fbpa_pkg::HEADER_BYTES_DEFAULT
) (
   input  wire                                  clock,
   input  wire                                  reset,
   input  fbpa_pkg::cmd_type                    cmd,
   output fbpa_pkg::stat_type                   stat,
   input  wire [31:0]                           pool_base,
   input  wire [15:0]                           block_capacity,
   input  wire                                  req_kind,
   input  wire [15:0]                           req_request_size,
   input  wire [31:0]                           req_free_address,
   output logic [2:0]                           rsp_status,
   output logic [31:0]                          rsp_granted_address,
   output logic [$clog2(NUM_BLOCKS+1)-1:0]      rsp_free_count
);

   localparam int CNT_W   = $clog2(NUM_BLOCKS + 1);
   localparam int IDX_W   = $clog2(NUM_BLOCKS);
   localparam int DC_W    = $clog2(IDX_W + 1);
   localparam int HDR_AL  = ((HEADER_BYTES + WORD_BYTES - 1) / WORD_BYTES) * WORD_BYTES;
   localparam int XW_W    = $clog2(65536 + WORD_BYTES);
   localparam int RSH     = XW_W + 3;
   localparam int RECIP   = (2 ** RSH) / WORD_BYTES;
   localparam int RECIP_W = RSH + 1;
   localparam int QP_W    = XW_W + RECIP_W;
   localparam int PITCH_W = $clog2(HDR_AL + 2 ** XW_W);
   localparam int SPAN_W  = PITCH_W + CNT_W;
   localparam int CMP_W   = (SPAN_W > 32) ? SPAN_W : 32;
   localparam int PROD_W  = IDX_W + PITCH_W;

   // latched request
   logic                kind_ff;
   logic [15:0]         size_ff;
   logic [31:0]         addr_ff;

   // capacity alignment and pitch
   logic [XW_W-1:0]     xw_ff, qest_ff, q_ff, cap_ff;
   logic [PITCH_W-1:0]  pitch_ff;
   logic [SPAN_W-1:0]   span_ff;
   logic [31:0]         off_ff;

   // divider
   logic [SPAN_W-1:0]   rem_ff, rem_in, div_ff;
   logic [IDX_W-1:0]    quo_ff;
   logic [DC_W-1:0]     dcnt_ff;
   logic                div_ge;

   // free stack control
   logic [CNT_W-1:0]    top_ff, low_ff, pop_pos;
   logic [IDX_W-1:0]    pos_ff;
   logic                unwr_ff;
   logic [IDX_W-1:0]    ram_rd_data, pick_idx;

   logic [PROD_W-1:0]   prod_ff;
   logic [31:0]         grant_ff;
   fbpa_pkg::status_type code_ff;

   logic [2:0]          rsp_status_ff;
   logic [31:0]         rsp_granted_ff;
   logic [CNT_W-1:0]    rsp_count_ff;

   logic [XW_W-1:0]     xw_in, qw, r_al;
   logic [QP_W-1:0]     qprod;

   assign xw_in   = XW_W'(block_capacity) + XW_W'(WORD_BYTES - 1);
   assign qprod   = QP_W'(xw_in) * QP_W'(RECIP);
   assign qw      = XW_W'(qest_ff * XW_W'(WORD_BYTES));
   assign r_al    = xw_ff - qw;
   assign pop_pos = top_ff - CNT_W'(1);
   assign div_ge  = rem_ff >= div_ff;
   assign rem_in  = div_ge ? (rem_ff - div_ff) : rem_ff;
   assign pick_idx = unwr_ff ? pos_ff : ram_rd_data;

   always_ff @(posedge clock) begin
      if (cmd.latch) begin
         kind_ff  <= req_kind;
         size_ff  <= req_request_size;
         addr_ff  <= req_free_address;
         grant_ff <= 32'd0;
      end
      if (cmd.align) begin
         xw_ff   <= xw_in;
         qest_ff <= XW_W'(qprod >> RSH);
      end
      if (cmd.corr) begin
         q_ff <= qest_ff + XW_W'(r_al >= XW_W'(WORD_BYTES));
      end
      if (cmd.pitch) begin
         cap_ff   <= XW_W'(q_ff * XW_W'(WORD_BYTES));
         pitch_ff <= PITCH_W'(HDR_AL) + PITCH_W'(q_ff * XW_W'(WORD_BYTES));
      end
      if (cmd.span) begin
         span_ff <= SPAN_W'(pitch_ff) * SPAN_W'(NUM_BLOCKS);
         off_ff  <= addr_ff - pool_base;
      end
      if (cmd.div_start) begin
         rem_ff  <= SPAN_W'(off_ff);
         div_ff  <= SPAN_W'(pitch_ff) << (IDX_W - 1);
         quo_ff  <= '0;
         dcnt_ff <= DC_W'(IDX_W - 1);
      end else if (cmd.div_step) begin
         rem_ff  <= rem_in;
         div_ff  <= div_ff >> 1;
         quo_ff  <= IDX_W'({quo_ff, div_ge});
         dcnt_ff <= dcnt_ff - DC_W'(1);
      end
      if (cmd.pop) begin
         pos_ff  <= pop_pos[IDX_W-1:0];
         unwr_ff <= pop_pos < low_ff;
      end
      if (cmd.mul) begin
         prod_ff <= PROD_W'(pick_idx) * PROD_W'(pitch_ff);
      end
      if (cmd.calc_addr) begin
         grant_ff <= pool_base + 32'(prod_ff) + 32'(HDR_AL);
      end
      if (cmd.set_code) begin
         code_ff <= cmd.code;
      end
      if (cmd.load_rsp) begin
         rsp_status_ff  <= code_ff;
         rsp_granted_ff <= grant_ff;
         rsp_count_ff   <= top_ff;
      end
   end

   // positions below the low watermark were never pushed and still hold their own index
   always_ff @(posedge clock) begin
      if (reset) begin
         top_ff <= CNT_W'(NUM_BLOCKS);
         low_ff <= CNT_W'(NUM_BLOCKS);
      end else if (cmd.pop) begin
         top_ff <= pop_pos;
         if (pop_pos < low_ff) begin
            low_ff <= pop_pos;
         end
      end else if (cmd.push) begin
         top_ff <= top_ff + CNT_W'(1);
      end
   end

   fbpa_ram #(
      .WIDTH (IDX_W),
      .DEPTH (NUM_BLOCKS)
   ) u_stack (
      .clock   (clock),
      .wr_en   (cmd.push),
      .wr_addr (top_ff[IDX_W-1:0]),
      .wr_data (quo_ff),
      .rd_en   (cmd.pop),
      .rd_addr (pop_pos[IDX_W-1:0]),
      .rd_data (ram_rd_data)
   );

   assign stat.kind_free   = fbpa_pkg::kind_type'(kind_ff) == fbpa_pkg::KIND_FREE;
   assign stat.empty       = top_ff == '0;
   assign stat.too_large   = XW_W'(size_ff) > cap_ff;
   assign stat.reject_free = (CMP_W'(off_ff) >= CMP_W'(span_ff))
                             || (top_ff == CNT_W'(NUM_BLOCKS));
   assign stat.div_last    = dcnt_ff == '0;

   assign rsp_status          = rsp_status_ff;
   assign rsp_granted_address = rsp_granted_ff;
   assign rsp_free_count      = rsp_count_ff;

endmodule

`default_nettype wire

// ----- hw/rtl/fixed_block_pool_allocator.sv -----
// fixed_block_pool_allocator: top level, joins registers, sequencer and datapath
// depends on fbpa_pkg, fbpa_csr, fbpa_ctrl, fbpa_datapath, fbpa_ram
//
// usage:
// - req channel carries allocate (kind 0, request_size) or free (kind 1, free_address)
//   transactions; rsp channel returns exactly one transaction per request with status,
//   granted_address (zero unless granted) and the free block count after the request
// - user writes pool_base/block_capacity on apb-style port only while idle; unenforced
// - one request is worked at a time; req_ready is high only between requests
// - a grant pops the stack, multiplies the index by the pitch, adds base and header;
//   a refused or ignored request goes straight to the response; a free runs the
//   restoring divider, one quotient bit per cycle, and then pushes the quotient
// - rsp_valid rises in the same cycle in which req_ready is back high
// - the result sits in an output register; a new request is accepted while it waits,
//   and that request stalls in its final cycle until the receiver takes the old one
// - reset is synchronous: the stack holds every block, base is 0, capacity is 64;
//   no clearing pass, a low watermark marks stack entries never pushed since reset
`default_nettype none

module fixed_block_pool_allocator #(
   parameter int NUM_BLOCKS   = fbpa_pkg::NUM_BLOCKS_DEFAULT,
   parameter int WORD_BYTES   = fbpa_pkg::WORD_BYTES_DEFAULT,
   parameter int HEADER_BYTES = fbpa_pkg::HEADER_BYTES_DEFAULT
) (
   input  wire                               clock,
   input  wire                               reset,
   input  wire                               req_valid,
   output logic                              req_ready,
   input  wire                               req_kind,
   input  wire [15:0]                        req_request_size,
   input  wire [31:0]                        req_free_address,
   output logic                              rsp_valid,
   input  wire                               rsp_ready,
   output logic [2:0]                        rsp_status,
   output logic [31:0]                       rsp_granted_address,
   output logic [$clog2(NUM_BLOCKS+1)-1:0]   rsp_free_count,
   input  wire                               psel,
   input  wire                               penable,
   input  wire                               pwrite,
   input  wire [fbpa_pkg::CSR_ADDR_W-1:0]    paddr,
   input  wire [31:0]                        pwdata,
   output logic [31:0]                       prdata,
   output logic                              pready
);

   logic [31:0]        pool_base;
   logic [15:0]        block_capacity;
   fbpa_pkg::cmd_type  cmd;
   fbpa_pkg::stat_type stat;

   fbpa_csr u_csr (
      .clock          (clock),
      .reset          (reset),
      .psel           (psel),
      .penable        (penable),
      .pwrite         (pwrite),
      .paddr          (paddr),
      .pwdata         (pwdata),
      .prdata         (prdata),
      .pready         (pready),
      .pool_base      (pool_base),
      .block_capacity (block_capacity)
   );

   fbpa_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   fbpa_datapath #(
      .NUM_BLOCKS   (NUM_BLOCKS),
      .WORD_BYTES   (WORD_BYTES),
      .HEADER_BYTES (HEADER_BYTES)
   ) u_datapath (
      .clock               (clock),
      .reset               (reset),
      .cmd                 (cmd),
      .stat                (stat),
      .pool_base           (pool_base),
      .block_capacity      (block_capacity),
      .req_kind            (req_kind),
      .req_request_size    (req_request_size),
      .req_free_address    (req_free_address),
      .rsp_status          (rsp_status),
      .rsp_granted_address (rsp_granted_address),
      .rsp_free_count      (rsp_free_count)
   );

   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request accepted while another is in work");

   a_grant_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status != fbpa_pkg::STATUS_GRANTED) |-> rsp_granted_address == 32'd0)
      else $error("nonzero address on a refused transaction");

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_free_count <= ($clog2(NUM_BLOCKS+1))'(NUM_BLOCKS))
      else $error("free count above pool size");

   a_freed_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == fbpa_pkg::STATUS_FREED) |-> rsp_free_count != '0)
      else $error("freed transaction reports an empty stack");

endmodule

`default_nettype wire

// ----- tb/sv/fixed_block_pool_allocator_test.sv -----
`timescale 1ns / 1ps
// fixed_block_pool_allocator_test: self-checking testbench of the fixed block pool allocator
// sends allocate and free transactions with random idling and checks every response
// depends on fbpa_pkg and fixed_block_pool_allocator

module fixed_block_pool_allocator_test;

   localparam int NUM_BLOCKS     = fbpa_pkg::NUM_BLOCKS_DEFAULT;
   localparam int WORD_BYTES     = fbpa_pkg::WORD_BYTES_DEFAULT;
   localparam int HEADER_BYTES   = fbpa_pkg::HEADER_BYTES_DEFAULT;
   localparam int CSR_ADDR_W     = fbpa_pkg::CSR_ADDR_W;
   localparam int COUNT_W        = $clog2(NUM_BLOCKS + 1);
   localparam int INDEX_W        = $clog2(NUM_BLOCKS);
   localparam int HEADER_ALIGNED = ((HEADER_BYTES + WORD_BYTES - 1) / WORD_BYTES) * WORD_BYTES;
   localparam int SETTLE_CYCLES  = 40;
   localparam int WATCHDOG_LIMIT = 1000;

   typedef struct packed {
      fbpa_pkg::status_type status;
      logic [31:0]          granted_address;
      logic [COUNT_W-1:0]   free_count;
   } pool_outcome_type;

   logic                  clock;
   logic                  reset;
   logic                  req_valid;
   logic                  req_ready;
   logic                  req_kind;
   logic [15:0]           req_request_size;
   logic [31:0]           req_free_address;
   logic                  rsp_valid;
   logic                  rsp_ready;
   logic [2:0]            rsp_status;
   logic [31:0]           rsp_granted_address;
   logic [COUNT_W-1:0]    rsp_free_count;
   logic                  psel;
   logic                  penable;
   logic                  pwrite;
   logic [CSR_ADDR_W-1:0] paddr;
   logic [31:0]           pwdata;
   logic [31:0]           prdata;
   logic                  pready;

   // predicted allocator state
   logic [31:0]        model_base;
   logic [15:0]        model_capacity;
   logic [INDEX_W-1:0] free_stack [NUM_BLOCKS];
   int unsigned        free_top;

   pool_outcome_type pending_outcomes [$];
   logic [31:0]      granted_blocks [$];

   int errors            = 0;
   int accepted_requests = 0;
   int settings_used     = 0;
   int status_seen [5]   = '{default: 0};
   int stall_left        = 0;
   int quiet_cycles      = 0;
   bit idle_off          = 1'b0;

   fixed_block_pool_allocator u_dut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_kind            (req_kind),
      .req_request_size    (req_request_size),
      .req_free_address    (req_free_address),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_status          (rsp_status),
      .rsp_granted_address (rsp_granted_address),
      .rsp_free_count      (rsp_free_count),
      .psel                (psel),
      .penable             (penable),
      .pwrite              (pwrite),
      .paddr               (paddr),
      .pwdata              (pwdata),
      .prdata              (prdata),
      .pready              (pready)
   );

   always begin
      clock = 1'b0;
      #10;
      clock = 1'b1;
      #10;
   end

   task automatic report_mismatch(input string message);
      if (errors < 100) begin
         $display("%0t mismatch: %s", $time, message);
      end
      errors++;
   endtask

   function automatic int unsigned aligned_capacity();
      return ((int'(model_capacity) + WORD_BYTES - 1) / WORD_BYTES) * WORD_BYTES;
   endfunction

   function automatic int unsigned block_pitch();
      return HEADER_ALIGNED + aligned_capacity();
   endfunction

   function automatic pool_outcome_type compute_pool_outcome(input logic kind,
                                                            input logic [15:0] size,
                                                            input logic [31:0] addr);
      pool_outcome_type  outcome;
      logic [31:0]       offset;
      longint unsigned   span;
      int unsigned       pitch;
      int unsigned       index;
      pitch  = block_pitch();
      span   = longint'(pitch) * NUM_BLOCKS;
      offset = addr - model_base;
      outcome.granted_address = '0;
      if (kind == fbpa_pkg::KIND_ALLOC) begin
         if (free_top == 0) begin
            outcome.status = fbpa_pkg::STATUS_POOL_FULL;
         end else if (size > aligned_capacity()) begin
            outcome.status = fbpa_pkg::STATUS_TOO_LARGE;
         end else begin
            free_top--;
            index = free_stack[free_top];
            outcome.granted_address = model_base + 32'(index * pitch + HEADER_ALIGNED);
            outcome.status = fbpa_pkg::STATUS_GRANTED;
            granted_blocks.push_back(outcome.granted_address);
         end
      end else if (offset >= span || free_top >= NUM_BLOCKS) begin
         // outside the pool, or a push onto a full stack
         outcome.status = fbpa_pkg::STATUS_IGNORED;
      end else begin
         free_stack[free_top] = INDEX_W'(offset / pitch);
         free_top++;
         outcome.status = fbpa_pkg::STATUS_FREED;
      end
      outcome.free_count = COUNT_W'(free_top);
      return outcome;
   endfunction

   task automatic send_request(input fbpa_pkg::kind_type kind, input logic [15:0] size,
                               input logic [31:0] addr);
      int               gap;
      pool_outcome_type outcome;
      gap = (!idle_off && $urandom_range(0, 3) == 0) ? $urandom_range(1, 15) : 0;
      @(negedge clock);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid        <= 1'b1;
      req_kind         <= kind;
      req_request_size <= size;
      req_free_address <= addr;
      do @(posedge clock); while (!req_ready);
      outcome = compute_pool_outcome(kind, size, addr);
      pending_outcomes.push_back(outcome);
      accepted_requests++;
   endtask

   task automatic settle();
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_outcomes.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic csr_write(input fbpa_pkg::csr_index_type index, input logic [31:0] data);
      @(negedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= CSR_ADDR_W'(4 * int'(index));
      pwdata  <= data;
      @(negedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      @(negedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      if (index == fbpa_pkg::CSR_POOL_BASE) begin
         model_base = data;
      end else begin
         model_capacity = data[15:0];
      end
   endtask

   task automatic csr_read(input fbpa_pkg::csr_index_type index, input logic [31:0] expected);
      @(negedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      paddr   <= CSR_ADDR_W'(4 * int'(index));
      @(negedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      if (prdata !== expected) begin
         report_mismatch($sformatf("register %s read %h expected %h",
                                   index.name(), prdata, expected));
      end
      @(negedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
   endtask

   task automatic configure_pool(input logic [31:0] base, input logic [15:0] capacity);
      settle();
      csr_write(fbpa_pkg::CSR_POOL_BASE, base);
      csr_write(fbpa_pkg::CSR_BLOCK_CAPACITY, {16'd0, capacity});
      csr_read(fbpa_pkg::CSR_POOL_BASE, base);
      csr_read(fbpa_pkg::CSR_BLOCK_CAPACITY, {16'd0, capacity});
      granted_blocks.delete();
      settings_used++;
   endtask

   task automatic send_allocate();
      int unsigned cap_a;
      logic [15:0] size;
      cap_a = aligned_capacity();
      case ($urandom_range(0, 9))
         0, 1, 2, 3, 4, 5: size = 16'($urandom_range(0, cap_a > 65535 ? 65535 : cap_a));
         6:       size = cap_a > 65535 ? 16'hFFFF : 16'(cap_a);
         7:       size = cap_a >= 65535 ? 16'hFFFF : 16'(cap_a + 1);
         default: size = 16'($urandom);
      endcase
      send_request(fbpa_pkg::KIND_ALLOC, size, $urandom);
   endtask

   task automatic send_free();
      int unsigned pitch;
      int unsigned pick;
      logic [31:0] addr;
      pitch = block_pitch();
      case ($urandom_range(0, 9))
         0, 1, 2, 3, 4, 5: begin
            if (granted_blocks.size() != 0) begin
               pick = $urandom_range(0, granted_blocks.size() - 1);
               addr = granted_blocks[pick];
               granted_blocks.delete(pick);
               // anywhere in the block, header and padding included
               if ($urandom_range(0, 1) == 1) begin
                  addr = addr - HEADER_ALIGNED + $urandom_range(0, pitch - 1);
               end
            end else begin
               addr = model_base + $urandom_range(0, pitch * NUM_BLOCKS - 1);
            end
         end
         6, 7: addr = model_base + $urandom_range(0, pitch * NUM_BLOCKS - 1);
         8: begin
            if ($urandom_range(0, 1) == 1) begin
               addr = model_base + pitch * NUM_BLOCKS + $urandom_range(0, 7);
            end else begin
               addr = model_base - 1 - $urandom_range(0, 7);
            end
         end
         default: addr = $urandom;
      endcase
      send_request(fbpa_pkg::KIND_FREE, 16'($urandom), addr);
   endtask

   task automatic test_register_access();
      csr_read(fbpa_pkg::CSR_POOL_BASE, fbpa_pkg::POOL_BASE_RESET);
      csr_read(fbpa_pkg::CSR_BLOCK_CAPACITY, {16'd0, fbpa_pkg::BLOCK_CAPACITY_RESET});
      configure_pool(32'hFFFF_FFFF, 16'hFFFF);
      configure_pool(32'h0000_0000, 16'h0000);
      configure_pool(fbpa_pkg::POOL_BASE_RESET, fbpa_pkg::BLOCK_CAPACITY_RESET);
   endtask

   task automatic test_allocate_limits();
      send_request(fbpa_pkg::KIND_ALLOC, 16'd0, $urandom);
      send_request(fbpa_pkg::KIND_ALLOC, 16'(aligned_capacity()), $urandom);
      send_request(fbpa_pkg::KIND_ALLOC, 16'(aligned_capacity() + 1), $urandom);
      send_request(fbpa_pkg::KIND_ALLOC, 16'hFFFF, $urandom);
   endtask

   task automatic test_free_boundaries();
      logic [31:0] span;
      span = block_pitch() * NUM_BLOCKS;
      send_request(fbpa_pkg::KIND_FREE, 16'($urandom), model_base + span);
      send_request(fbpa_pkg::KIND_FREE, 16'($urandom), model_base - 1);
      send_request(fbpa_pkg::KIND_FREE, 16'($urandom), model_base + span - 1);
      // block 0 was never handed out, so this is a double free
      send_request(fbpa_pkg::KIND_FREE, 16'($urandom), model_base);
      // stack is full again
      send_request(fbpa_pkg::KIND_FREE, 16'($urandom), model_base + HEADER_ALIGNED);
   endtask

   task automatic test_zero_capacity();
      configure_pool(32'hFFFF_FFF8, 16'h0000);
      send_request(fbpa_pkg::KIND_ALLOC, 16'd1, $urandom);
      send_request(fbpa_pkg::KIND_ALLOC, 16'd0, $urandom);
      send_request(fbpa_pkg::KIND_FREE, 16'($urandom), granted_blocks[$]);
      send_request(fbpa_pkg::KIND_FREE, 16'($urandom),
                   model_base + block_pitch() * NUM_BLOCKS);
   endtask

   task automatic test_max_capacity();
      configure_pool(32'hFFFF_FFFF, 16'hFFFF);
      send_request(fbpa_pkg::KIND_ALLOC, 16'hFFFF, $urandom);
      send_request(fbpa_pkg::KIND_FREE, 16'($urandom), granted_blocks[$]);
   endtask

   task automatic test_mixed_traffic(input logic [31:0] base, input logic [15:0] capacity,
                                     input int target);
      int goal;
      bit filling;
      configure_pool(base, capacity);
      goal    = accepted_requests + target;
      filling = 1'b1;
      while (accepted_requests < goal) begin
         // sweep the stack between empty and full
         if (free_top == 0) begin
            filling = 1'b0;
         end else if (free_top == NUM_BLOCKS) begin
            filling = 1'b1;
         end
         if (($urandom_range(0, 99) < 85) == filling) begin
            send_allocate();
         end else begin
            send_free();
         end
      end
   endtask

   always @(negedge clock) begin
      if (stall_left > 0 && !idle_off) begin
         stall_left <= stall_left - 1;
      end else if (!idle_off && $urandom_range(0, 7) == 0) begin
         rsp_ready  <= 1'b0;
         stall_left <= $urandom_range(0, 14);
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      pool_outcome_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_outcomes.size() == 0) begin
            report_mismatch($sformatf("response with nothing pending, status %0d",
                                      rsp_status));
         end else begin
            want = pending_outcomes.pop_front();
            if (rsp_status !== want.status) begin
               report_mismatch($sformatf("status %0d expected %s",
                                         rsp_status, want.status.name()));
            end
            if (rsp_granted_address !== want.granted_address) begin
               report_mismatch($sformatf("granted_address %h expected %h",
                                         rsp_granted_address, want.granted_address));
            end
            if (rsp_free_count !== want.free_count) begin
               report_mismatch($sformatf("free_count %0d expected %0d",
                                         rsp_free_count, want.free_count));
            end
            status_seen[int'(want.status)]++;
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("watchdog: no transaction for %0d cycles", WATCHDOG_LIMIT);
         $display("== FAIL ==");
         $finish;
      end
   end

   initial begin
      reset            = 1'b1;
      req_valid        = 1'b0;
      req_kind         = fbpa_pkg::KIND_ALLOC;
      req_request_size = '0;
      req_free_address = '0;
      rsp_ready        = 1'b0;
      psel             = 1'b0;
      penable          = 1'b0;
      pwrite           = 1'b0;
      paddr            = '0;
      pwdata           = '0;
      model_base       = fbpa_pkg::POOL_BASE_RESET;
      model_capacity   = fbpa_pkg::BLOCK_CAPACITY_RESET;
      free_top         = NUM_BLOCKS;
      for (int i = 0; i < NUM_BLOCKS; i++) begin
         free_stack[i] = INDEX_W'(i);
      end
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_register_access();
      test_allocate_limits();
      test_free_boundaries();
      test_zero_capacity();
      test_max_capacity();
      test_mixed_traffic(fbpa_pkg::POOL_BASE_RESET, fbpa_pkg::BLOCK_CAPACITY_RESET, 200);
      test_mixed_traffic($urandom, 16'($urandom_range(1, 200)), 200);
      test_mixed_traffic(32'hFFFF_FFFF, 16'hFFFF, 150);
      test_mixed_traffic($urandom, 16'h0000, 150);
      test_mixed_traffic($urandom, 16'h0001, 150);
      test_mixed_traffic($urandom, 16'($urandom), 150);
      idle_off = 1'b1;
      test_mixed_traffic(32'h0000_0000, 16'($urandom_range(1, 64)), 300);
      settle();

      $display("covered %0d requests over %0d register settings",
               accepted_requests, settings_used);
      $display("responses: %0d granted, %0d pool full, %0d too large, %0d freed, %0d ignored",
               status_seen[fbpa_pkg::STATUS_GRANTED], status_seen[fbpa_pkg::STATUS_POOL_FULL],
               status_seen[fbpa_pkg::STATUS_TOO_LARGE], status_seen[fbpa_pkg::STATUS_FREED],
               status_seen[fbpa_pkg::STATUS_IGNORED]);
      if (errors == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule

// ----- filelist.f -----
hw/rtl/fbpa_pkg.sv
hw/rtl/fbpa_ram.sv
hw/rtl/fbpa_csr.sv
hw/rtl/fbpa_ctrl.sv
hw/rtl/fbpa_datapath.sv
hw/rtl/fixed_block_pool_allocator.sv
tb/sv/fixed_block_pool_allocator_test.sv
